// File: sv/fta_pkg.sv
// Shared types and constants of the truncating single-precision arithmetic unit.
package fta_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned SigWidth  = 24;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned QueueDepth = 2;

   localparam logic [ExpWidth-1:0] ExpBias = 8'd127;
   localparam logic [ExpWidth-1:0] DivBias = 8'd126;
   localparam logic [SigWidth-1:0] HiddenOne = 24'h800000;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      cmd_type                command;
      logic                   zero_out;
      logic                   sign;
      logic [ExpWidth-1:0]    exp;
      logic [SigWidth-1:0]    sig_a;
      logic [SigWidth-1:0]    sig_b;
      logic                   sub_mag;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_NORM,
      ST_DONE
   } state_type;

endpackage

// File: sv/fta_front.sv
// Front end: accepts a command and classifies and aligns its operands.
module fta_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  fta_pkg::cmd_type         in_command,
   input  logic [31:0]              in_a,
   input  logic [31:0]              in_b,
   output logic                     out_valid,
   output fta_pkg::work_type        out_item,
   input  logic                     out_ready
);

   logic                 valid_ff, valid_in;
   fta_pkg::work_type    item_ff, item_in;

   logic        sa, sb, is_sub, a_zero, b_zero;
   logic [7:0]  ea, eb, d;
   logic [23:0] ma, mb, ma_al, mb_al;

   always_comb begin
      sa     = in_a[31];
      is_sub = (in_command == fta_pkg::CMD_SUB);
      sb     = in_b[31] ^ is_sub;
      ea     = in_a[30:23];
      eb     = in_b[30:23];
      ma     = {1'b1, in_a[22:0]};
      mb     = {1'b1, in_b[22:0]};
      a_zero = (ea == 8'd0) && (in_a[22:0] == 23'd0);
      b_zero = (eb == 8'd0) && (in_b[22:0] == 23'd0);
      ma_al  = ma;
      mb_al  = mb;
      d      = (ea < eb) ? (eb - ea) : (ea - eb);
      item_in = item_ff;
      item_in.command = in_command;
      item_in.zero_out = 1'b0;
      item_in.sub_mag  = 1'b0;
      case (in_command)
         fta_pkg::CMD_ADD, fta_pkg::CMD_SUB: begin
            if (ea < eb) begin
               ma_al = (d >= 8'd24) ? 24'd0 : (ma >> d);
               item_in.exp = eb;
            end else begin
               mb_al = (d >= 8'd24) ? 24'd0 : (mb >> d);
               item_in.exp = ea;
            end
            item_in.sub_mag = sa ^ sb;
            // Larger aligned magnitude goes first and lends its sign.
            if (ma_al >= mb_al) begin
               item_in.sign  = sa;
               item_in.sig_a = ma_al;
               item_in.sig_b = mb_al;
            end else begin
               item_in.sign  = sb;
               item_in.sig_a = mb_al;
               item_in.sig_b = ma_al;
            end
         end
         fta_pkg::CMD_MUL: begin
            item_in.sign     = sa ^ in_b[31];
            item_in.exp      = ea + eb - fta_pkg::ExpBias;
            item_in.sig_a    = ma;
            item_in.sig_b    = mb;
            item_in.zero_out = a_zero || b_zero;
         end
         default: begin
            item_in.sign  = sa ^ in_b[31];
            item_in.exp   = fta_pkg::DivBias + ea - eb;
            item_in.sig_a = ma;
            item_in.sig_b = mb;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (in_valid)  valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: sv/fta_queue.sv
// Short queue that decouples the front end from the execution back end.
module fta_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fta_pkg::work_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output fta_pkg::work_type  pop_item
);

   localparam int unsigned PtrW = $clog2(fta_pkg::QueueDepth);

   fta_pkg::work_type     mem_ff [fta_pkg::QueueDepth];
   logic [PtrW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]         cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = wr_ff + 1'b1;
      if (pop)  rd_in = rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign full      = (cnt_ff == (PtrW+1)'(fta_pkg::QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = mem_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance");

endmodule

// File: sv/fta_back.sv
// Back end: carries out the sum, product or quotient and normalises it.
module fta_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fta_pkg::work_type  in_item,
   output logic               in_pop,
   output logic               res_valid,
   output logic [31:0]        res_word
);

   fta_pkg::state_type state_ff, state_in;

   logic [47:0] acc_ff, acc_in;      // product, or quotient in low bits
   logic [24:0] rem_ff, rem_in;      // division remainder
   logic [23:0] div_ff, div_in;
   logic [23:0] mcand_ff, mcand_in;
   logic [23:0] mplier_ff, mplier_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  exp_ff, exp_in;
   logic        sign_ff, sign_in;
   logic        zero_ff, zero_in;
   logic [24:0] sig_ff, sig_in;
   logic [31:0] word_ff, word_in;

   logic [25:0] rem_sh;
   logic [24:0] sum;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fta_pkg::ST_IDLE:
            if (in_valid) begin
               case (in_item.command)
                  fta_pkg::CMD_MUL: state_in = in_item.zero_out ? fta_pkg::ST_DONE
                                                                : fta_pkg::ST_MUL;
                  fta_pkg::CMD_DIV: state_in = fta_pkg::ST_DIV;
                  default:          state_in = fta_pkg::ST_NORM;
               endcase
            end
         fta_pkg::ST_MUL: if (cnt_ff == 5'd0) state_in = fta_pkg::ST_NORM;
         fta_pkg::ST_DIV: if (cnt_ff == 5'd0) state_in = fta_pkg::ST_NORM;
         fta_pkg::ST_NORM:
            if (zero_ff || (sig_ff[24:23] == 2'b01)) state_in = fta_pkg::ST_DONE;
         default: state_in = fta_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_pop    = (state_ff == fta_pkg::ST_IDLE) && in_valid;
      res_valid = (state_ff == fta_pkg::ST_DONE);
      res_word  = word_ff;
   end

   always_comb begin
      acc_in = acc_ff; rem_in = rem_ff; div_in = div_ff;
      mcand_in = mcand_ff; mplier_in = mplier_ff; cnt_in = cnt_ff;
      exp_in = exp_ff; sign_in = sign_ff; zero_in = zero_ff;
      sig_in = sig_ff; word_in = word_ff;
      rem_sh = {rem_ff, 1'b0};
      sum    = '0;
      case (state_ff)
         fta_pkg::ST_IDLE: begin
            exp_in   = in_item.exp;
            sign_in  = in_item.sign;
            zero_in  = 1'b0;
            acc_in   = '0;
            mcand_in = in_item.sig_a;
            mplier_in = in_item.sig_b;
            rem_in   = {1'b0, in_item.sig_a};
            div_in   = in_item.sig_b;
            if (in_item.command == fta_pkg::CMD_MUL) begin
               cnt_in  = 5'd23;
               zero_in = in_item.zero_out;
               word_in = '0;
            end else if (in_item.command == fta_pkg::CMD_DIV) begin
               cnt_in = 5'd23;
               // The integer quotient bit is settled first, so the remainder
               // stays below the divisor for the shifting steps.
               if (in_item.sig_a >= in_item.sig_b) begin
                  rem_in = {1'b0, in_item.sig_a - in_item.sig_b};
                  acc_in = 48'd1;
               end
            end else begin
               sum = in_item.sub_mag ? ({1'b0, in_item.sig_a} - {1'b0, in_item.sig_b})
                                     : ({1'b0, in_item.sig_a} + {1'b0, in_item.sig_b});
               sig_in  = sum;
               zero_in = (sum == 25'd0);
            end
         end
         fta_pkg::ST_MUL: begin
            // One shift-and-add step per cycle, multiplier bit first from the top.
            acc_in = {acc_ff[46:0], 1'b0} + (mplier_ff[23] ? {24'd0, mcand_ff} : 48'd0);
            mplier_in = {mplier_ff[22:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (acc_in[47]) begin
                  sig_in = {1'b0, acc_in[47:24]};
                  exp_in = exp_ff + 8'd1;
               end else begin
                  sig_in = {1'b0, acc_in[46:23]};
               end
            end
         end
         fta_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_sh >= {2'b00, div_ff}) begin
               rem_in = 25'(rem_sh - {2'b00, div_ff});
               acc_in = {acc_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_sh[24:0];
               acc_in = {acc_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) sig_in = acc_in[24:0];
         end
         fta_pkg::ST_NORM: begin
            if (zero_ff) begin
               word_in = '0;
            end else if (sig_ff[24]) begin
               sig_in = sig_ff >> 1;
               exp_in = exp_ff + 8'd1;
            end else if (!sig_ff[23]) begin
               sig_in = sig_ff << 1;
               exp_in = exp_ff - 8'd1;
            end else begin
               word_in = {sign_ff, exp_ff, sig_ff[22:0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fta_pkg::ST_IDLE;
      else       state_ff <= state_in;
      acc_ff <= acc_in; rem_ff <= rem_in; div_ff <= div_in;
      mcand_ff <= mcand_in; mplier_ff <= mplier_in; cnt_ff <= cnt_in;
      exp_ff <= exp_in; sign_ff <= sign_in; zero_ff <= zero_in;
      sig_ff <= sig_in; word_ff <= word_in;
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      in_pop |=> (state_ff != fta_pkg::ST_IDLE)) else $error("pop without start");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> !res_valid) else $error("result held too long");
   a_norm_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fta_pkg::ST_NORM && zero_ff) |=> (word_ff == 32'd0))
      else $error("zero result not cleared");

endmodule

// File: sv/float32_truncating_arith_unit_top.sv
// Top level of the truncating single-precision arithmetic unit.
// Each command takes one word pair and gives one result beat, shown with
// rsp_valid high for exactly one cycle; the receiver cannot hold it off.
// With the back end idle, an add or subtract result is summed on entry and then
// normalised one shift at a time (up to 23 shifts). Unless either operand is
// zero, multiply runs a 24-step shift-and-add loop before normalising; divide
// settles the integer quotient bit on entry, runs a 24-step restoring division
// loop and normalises with at most one right shift. A front stage and a
// two-entry queue let up to three further commands be accepted while the back
// end works; busy rises when the front stage and the queue are all occupied.
module float32_truncating_arith_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result
);

   logic               front_valid, q_full, q_nempty, q_pop, push;
   fta_pkg::work_type  front_item, q_item;

   // The front stage drains into the queue whenever the queue has room.
   assign push = front_valid && !q_full;
   assign busy = front_valid && q_full;

   fta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_command (fta_pkg::cmd_type'(req_command)),
      .in_a       (req_operand_a),
      .in_b       (req_operand_b),
      .out_valid  (front_valid),
      .out_item   (front_item),
      .out_ready  (push)
   );

   fta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_nempty),
      .pop_item  (q_item)
   );

   fta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_nempty),
      .in_item   (q_item),
      .in_pop    (q_pop),
      .res_valid (rsp_valid),
      .res_word  (rsp_result)
   );

endmodule
